FILE: rtl/core/hpq_pkg.sv
// ---------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants of the max-heap priority queue.
// ---------------------------------------------------------------------------
package hpq_pkg;

	localparam int HPQ_CAPACITY = 64;
	localparam int DATA_W       = 32;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY
	} hpq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DN_LAST,
		S_DN_L,
		S_DN_R,
		S_FIN,
		S_DONE
	} hpq_state_t;

endpackage

FILE: rtl/core/hpq_ifs.sv
// ---------------------------------------------------------------------------
// hpq_ifs
// Command and result channels of the max-heap priority queue.
// ---------------------------------------------------------------------------
interface hpq_req_if;
	import hpq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface hpq_res_if #(
	parameter int CW = 7
);
	import hpq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic [CW-1:0]            count;
	logic                     empty_res;
	hpq_status_t              status;

	modport source (output valid, output top_value, output count, output empty_res,
		output status, input ready);
	modport sink   (input valid, input top_value, input count, input empty_res,
		input status, output ready);
endinterface

FILE: rtl/core/hpq_mem.sv
// ---------------------------------------------------------------------------
// hpq_mem
// Heap entry store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module hpq_mem #(
	parameter int DEPTH = hpq_pkg::HPQ_CAPACITY,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [hpq_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr,
	output logic signed [hpq_pkg::DATA_W-1:0] rdata
);
	import hpq_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/hpq_ctrl.sv
// ---------------------------------------------------------------------------
// hpq_ctrl
// Sift sequencer: walks the moving entry up or down the tree, one memory
// read per step, keeping the moving value in a register (hole method).
// ---------------------------------------------------------------------------
module hpq_ctrl #(
	parameter int CAPACITY = hpq_pkg::HPQ_CAPACITY,
	localparam int AW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hpq_req_if.sink                           cmd,
	// memory port
	output logic                              we,
	output logic [AW-1:0]                     waddr,
	output logic signed [hpq_pkg::DATA_W-1:0] wdata,
	output logic [AW-1:0]                     raddr,
	input  logic signed [hpq_pkg::DATA_W-1:0] rdata,
	// finished operation
	input  logic                              res_free,
	output logic                              done,
	output logic signed [hpq_pkg::DATA_W-1:0] top_value,
	output logic [CW-1:0]                     count,
	output hpq_pkg::hpq_status_t              status
);
	import hpq_pkg::*;

	hpq_state_t               state_q, state_n;
	logic [CW-1:0]            pos_q, pos_n;
	logic [CW-1:0]            cnt_q, cnt_n;
	logic signed [DATA_W-1:0] val_q, val_n;
	logic signed [DATA_W-1:0] lval_q, lval_n;
	logic signed [DATA_W-1:0] top_q;
	hpq_status_t              stat_q, stat_n;

	logic [CW-1:0]            pos_m1, par, newpos, newpar_m1, cnt_m1, gpar_m1;
	logic [CW:0]              left_w, right_w, n_w, grand, grand_m1, right_m1;
	logic                     mv;
	logic [CW-1:0]            mv_pos;
	logic signed [DATA_W-1:0] mv_val, bestv;

	assign pos_m1    = pos_q - 1'b1;
	assign par       = pos_q >> 1;
	assign gpar_m1   = (par >> 1) - 1'b1;
	assign newpos    = cnt_q + 1'b1;
	assign newpar_m1 = (newpos >> 1) - 1'b1;
	assign cnt_m1    = cnt_q - 1'b1;
	assign left_w    = {pos_q, 1'b0};
	assign right_w   = {pos_q, 1'b1};
	assign right_m1  = right_w - 1'b1;
	assign n_w       = {1'b0, cnt_q};
	assign grand     = {mv_pos, 1'b0};
	assign grand_m1  = grand - 1'b1;

	assign cmd.ready = (state_q == S_IDLE);

	// child selection: left wins over the entry only if strictly greater,
	// right only if strictly greater than the best so far
	always_comb begin
		bestv  = val_q;
		mv     = 1'b0;
		mv_pos = pos_q;
		mv_val = val_q;
		if (state_q == S_DN_L) begin
			if (rdata > val_q) begin
				mv     = 1'b1;
				mv_pos = left_w[CW-1:0];
				mv_val = rdata;
			end
		end else begin
			if (lval_q > val_q) begin
				bestv  = lval_q;
				mv     = 1'b1;
				mv_pos = left_w[CW-1:0];
				mv_val = lval_q;
			end
			if (rdata > bestv) begin
				mv     = 1'b1;
				mv_pos = right_w[CW-1:0];
				mv_val = rdata;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		pos_n   = pos_q;
		cnt_n   = cnt_q;
		val_n   = val_q;
		lval_n  = lval_q;
		stat_n  = stat_q;
		we      = 1'b0;
		waddr   = pos_m1[AW-1:0];
		wdata   = val_q;
		raddr   = newpar_m1[AW-1:0];
		done    = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					stat_n = STAT_OK;
					if (cmd.kind == KIND_PUSH) begin
						if (cnt_q == CW'(CAPACITY)) begin
							stat_n  = STAT_FULL;
							state_n = S_DONE;
						end else begin
							cnt_n = newpos;
							pos_n = newpos;
							val_n = cmd.value;
							if (cnt_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = cmd.value;
								state_n = S_DONE;
							end else begin
								raddr   = newpar_m1[AW-1:0];
								state_n = S_UP;
							end
						end
					end else begin
						if (cnt_q == '0) begin
							stat_n  = STAT_EMPTY;
							state_n = S_DONE;
						end else begin
							cnt_n = cnt_m1;
							pos_n = CW'(1);
							if (cnt_m1 == '0) begin
								state_n = S_DONE;
							end else begin
								raddr   = cnt_m1[AW-1:0];
								state_n = S_DN_LAST;
							end
						end
					end
				end
			end
			S_UP: begin
				// rdata holds the parent of pos
				if (rdata < val_q) begin
					we    = 1'b1;
					wdata = rdata;
					pos_n = par;
					if (par == CW'(1)) begin
						state_n = S_FIN;
					end else begin
						raddr = gpar_m1[AW-1:0];
					end
				end else begin
					we      = 1'b1;
					state_n = S_DONE;
				end
			end
			S_DN_LAST: begin
				// last entry becomes the moving value at the root
				val_n = rdata;
				if (left_w > n_w) begin
					we      = 1'b1;
					wdata   = rdata;
					state_n = S_DONE;
				end else begin
					raddr   = AW'(1);
					state_n = S_DN_L;
				end
			end
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L && right_w <= n_w) begin
					lval_n  = rdata;
					raddr   = right_m1[AW-1:0];
					state_n = S_DN_R;
				end else if (mv) begin
					we    = 1'b1;
					wdata = mv_val;
					pos_n = mv_pos;
					if (grand <= n_w) begin
						raddr   = grand_m1[AW-1:0];
						state_n = S_DN_L;
					end else begin
						state_n = S_FIN;
					end
				end else begin
					we      = 1'b1;
					state_n = S_DONE;
				end
			end
			S_FIN: begin
				we      = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					done    = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			stat_q  <= STAT_OK;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			stat_q  <= stat_n;
		end
	end

	// root copy, so the top is known without a memory read
	always_ff @(posedge clk) begin
		pos_q  <= pos_n;
		val_q  <= val_n;
		lval_q <= lval_n;
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
	end

	assign top_value = (cnt_q == '0) ? '0 : top_q;
	assign count     = cnt_q;
	assign status    = stat_q;

endmodule

FILE: rtl/core/max_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed words with push and pop-maximum commands.
// ---------------------------------------------------------------------------
// One command word in, one result word out: top value, count, empty flag
// and status (done, push dropped when full, pop on empty ignored). The heap
// sits in a single-port-read, single-port-write memory of CAPACITY entries;
// the sift walks it one level at a time: a push needs one parent read per
// level, a pop two child reads per level below the root through the one
// read port. One command is processed at a time; the result register lets
// the next command start while a result waits to be taken.
module max_heap_priority_queue #(
	parameter int CAPACITY = hpq_pkg::HPQ_CAPACITY,
	localparam int AW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	hpq_req_if.sink    cmd,
	hpq_res_if.source  res
);
	import hpq_pkg::*;

	logic                     we;
	logic [AW-1:0]            waddr, raddr;
	logic signed [DATA_W-1:0] wdata, rdata;
	logic                     done, res_free;
	logic signed [DATA_W-1:0] top_value;
	logic [CW-1:0]            count;
	hpq_status_t              status;

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] top_value_q;
	logic [CW-1:0]            count_q;
	hpq_status_t              status_q;

	hpq_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	hpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata),
		.res_free  (res_free),
		.done      (done),
		.top_value (top_value),
		.count     (count),
		.status    (status)
	);

	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			top_value_q <= top_value;
			count_q     <= count;
			status_q    <= status;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.top_value = top_value_q;
	assign res.count     = count_q;
	assign res.empty_res = (count_q == '0);
	assign res.status    = status_q;

endmodule

FILE: test/hpq_heap_checker.sv
// ---------------------------------------------------------------------------
// hpq_heap_checker
// Watches both channels of the heap queue, keeps its own max-heap and
// compares every result word with the word that heap predicts.
// ---------------------------------------------------------------------------
module hpq_heap_checker (
	input  logic clk,
	input  logic arst_n,
	hpq_req_if   cmd,
	hpq_res_if   res,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hpq_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [6:0]               count;
		logic                     empty_res;
		hpq_status_t              status;
	} heap_result_t;

	logic signed [DATA_W-1:0] heap_mem [HPQ_CAPACITY];
	int unsigned              held;
	heap_result_t             results_due[$];
	heap_result_t             want, got;
	int                       fails;

	// Applies one command to the local heap and returns the result word.
	function automatic heap_result_t heap_apply(input logic kind,
		input logic signed [DATA_W-1:0] value);
		heap_result_t             r;
		int unsigned              pos, lc, rc, best;
		logic signed [DATA_W-1:0] bestv, t;
		logic                     settled;
		r.status = STAT_OK;
		if (kind == KIND_PUSH) begin
			if (held >= HPQ_CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				heap_mem[held] = value;
				held++;
				pos = held;
				// climb only past a strictly smaller parent
				while (pos > 1 && heap_mem[pos/2-1] < heap_mem[pos-1]) begin
					t = heap_mem[pos/2-1];
					heap_mem[pos/2-1] = heap_mem[pos-1];
					heap_mem[pos-1] = t;
					pos = pos / 2;
				end
			end
		end else if (held == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			held--;
			if (held > 0) begin
				heap_mem[0] = heap_mem[held];
				pos = 1;
				settled = 1'b0;
				while (!settled) begin
					lc = 2 * pos;
					rc = lc + 1;
					best = pos;
					bestv = heap_mem[pos-1];
					if (lc > held) begin
						settled = 1'b1;
					end else begin
						if (heap_mem[lc-1] > bestv) begin
							bestv = heap_mem[lc-1];
							best = lc;
						end
						if (rc <= held && heap_mem[rc-1] > bestv)
							best = rc;
						if (best == pos) begin
							settled = 1'b1;
						end else begin
							t = heap_mem[pos-1];
							heap_mem[pos-1] = heap_mem[best-1];
							heap_mem[best-1] = t;
							pos = best;
						end
					end
				end
			end
		end
		r.top_value = (held != 0) ? heap_mem[0] : '0;
		r.count     = 7'(held);
		r.empty_res = (held == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			results_due.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// results are checked before this edge's command is predicted
			if (res.valid && res.ready) begin
				got.top_value = res.top_value;
				got.count     = res.count;
				got.empty_res = res.empty_res;
				got.status    = res.status;
				if (results_due.size() == 0) begin
					$display("%0t: result word with none due: top %0d count %0d empty %0b status %0d",
						$time, got.top_value, got.count, got.empty_res, got.status);
					fails++;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						$display("%0t: expected top %0d count %0d empty %0b status %0d",
							$time, want.top_value, want.count, want.empty_res, want.status);
						$display("%0t: actual   top %0d count %0d empty %0b status %0d",
							$time, got.top_value, got.count, got.empty_res, got.status);
						fails++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				results_due = {results_due, heap_apply(cmd.kind, cmd.value)};
			fail_count <= fails;
			pending <= results_due.size();
		end
	end

endmodule

FILE: test/tb_max_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Drives push and pop words into the heap queue under varying idle and
// stall patterns; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_max_heap_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import hpq_pkg::*;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int RANDOM_PER_PHASE = 325;

	logic        clk;
	logic        arst_n;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int          fail_count;
	int          pending;

	hpq_req_if          cmd_if ();
	hpq_res_if #(.CW(7)) res_if ();

	max_heap_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if.sink),
		.res    (res_if.source)
	);

	hpq_heap_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.res        (res_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Mix of full-range words, a narrow band for equal keys, and extremes.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7:       return int'($urandom_range(8)) - 4;
			8:             return VAL_MAX;
			default:       return VAL_MIN;
		endcase
	endfunction

	task automatic send_word(input logic kind, input logic signed [DATA_W-1:0] value);
		if ($urandom_range(99) < idle_pct) begin
			cmd_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.kind  <= kind;
		cmd_if.value <= value;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int          left_items;
		int          blk;
		int unsigned push_pct;
		logic        kind;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		cmd_if.valid <= 1'b0;
		cmd_if.kind  <= KIND_PUSH;
		cmd_if.value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, lone entry in and out, extremes, equal keys
		send_word(KIND_POP, 32'sd7);
		send_word(KIND_PUSH, VAL_MIN);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, VAL_MAX);
		send_word(KIND_PUSH, '0);
		send_word(KIND_PUSH, VAL_MAX);
		send_word(KIND_PUSH, -32'sd1);
		send_word(KIND_PUSH, VAL_MAX);
		send_word(KIND_PUSH, 32'sd5);
		send_word(KIND_PUSH, 32'sd5);
		send_word(KIND_PUSH, VAL_MIN);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_PUSH, 32'sh5555_5555);
		send_word(KIND_PUSH, 32'shAAAA_AAAA);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);
		send_word(KIND_POP, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 74; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 74; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			left_items = RANDOM_PER_PHASE;
			while (left_items > 0) begin
				// runs biased toward filling, draining or holding the level
				blk = $urandom_range(40, 150);
				case ($urandom_range(2))
					0:       push_pct = 90;
					1:       push_pct = 20;
					default: push_pct = 55;
				endcase
				for (int i = 0; i < blk && left_items > 0; i++) begin
					kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
					send_word(kind, pick_value());
					left_items--;
				end
			end
		end
		cmd_if.valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
